[src/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Shared constants, codes and types of the transition table sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

    localparam int MAX_STATES  = 16;
    localparam int MAX_ACTIONS = 4;

    localparam int ST_W    = $clog2(MAX_STATES);
    localparam int ACT_W   = $clog2(MAX_ACTIONS);
    localparam int ADDR_W  = ACT_W + ST_W + ST_W;
    localparam int DEPTH   = MAX_ACTIONS * MAX_STATES * MAX_STATES;
    localparam int PROB_W  = 17;
    localparam int DRAW_W  = 16;
    localparam int SUM_W   = PROB_W + ST_W;
    localparam int CFG_W   = 5;
    localparam int OP_W    = 2;

    localparam logic [PROB_W-1:0] ONE_Q16    = PROB_W'(65536);
    localparam logic [CFG_W-1:0]  ROW_MAX    = CFG_W'(MAX_STATES);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_SAMPLE = 2'd2
    } op_t;

    // control of the accumulate/compare unit
    typedef struct packed {
        logic clear;
        logic add;
    } acc_ctrl_t;

endpackage

`default_nettype wire

[src/tts_mem.sv]
// ----------------------------------------------------------------------------
// tts_mem
// Probability table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_mem (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [tts_pkg::ADDR_W-1:0]  wr_addr,
    input  wire logic [tts_pkg::PROB_W-1:0]  wr_data,
    input  wire logic [tts_pkg::ADDR_W-1:0]  rd_addr,
    output logic      [tts_pkg::PROB_W-1:0]  rd_data
);

    logic [tts_pkg::PROB_W-1:0] mem [tts_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[src/tts_accum.sv]
// ----------------------------------------------------------------------------
// tts_accum
// Running sum of row entries and compare of the draw against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_accum (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tts_pkg::acc_ctrl_t          ctrl,
    input  wire logic [tts_pkg::PROB_W-1:0]  addend,
    input  wire logic [tts_pkg::DRAW_W-1:0]  draw,
    output logic                             hit
);

    logic [tts_pkg::SUM_W-1:0] sum_reg;
    logic [tts_pkg::SUM_W-1:0] sum_next;
    logic [tts_pkg::SUM_W-1:0] sum_add;

    assign sum_add = sum_reg + tts_pkg::SUM_W'(addend);
    // hit is judged on the sum that includes the entry being added
    assign hit     = tts_pkg::SUM_W'(draw) <= sum_add;

    always_comb
    begin
        sum_next = sum_reg;
        if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else if (ctrl.add)
        begin
            sum_next = sum_add;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

[src/transition_table_sampler.sv]
// ----------------------------------------------------------------------------
// transition_table_sampler
// Transition probability table with inverse-CDF sampling over one row.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | op, cur_state, act, target_state,
//          |           |                      | prob_value, uniform_draw, fallback_pick
//  out     | output    | out_valid / out_ready| read_value, picked_state, fell_through
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (states_in_use)
//
//  Write: taken in idle. Read: read issue, read data, done. Sample: a walk over
//  a row of L entries (L = min(states_in_use, 16)), ending early on a hit,
//  straight to done for L = 0; one table entry per cycle from the single read
//  port into the accumulator. After reset a clearing pass writes zero to all
//  1024 entries, one per cycle; no transaction is accepted on in meanwhile,
//  cfg is always taken. A result waits in the output register while the next
//  item is accepted; a new result stalls in the done state until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module transition_table_sampler (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tts_pkg::OP_W-1:0]    op,
    input  wire logic [tts_pkg::ST_W-1:0]    cur_state,
    input  wire logic [tts_pkg::ACT_W-1:0]   act,
    input  wire logic [tts_pkg::ST_W-1:0]    target_state,
    input  wire logic [tts_pkg::PROB_W-1:0]  prob_value,
    input  wire logic [tts_pkg::DRAW_W-1:0]  uniform_draw,
    input  wire logic [tts_pkg::ST_W-1:0]    fallback_pick,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [tts_pkg::PROB_W-1:0]  read_value,
    output logic      [tts_pkg::ST_W-1:0]    picked_state,
    output logic                             fell_through,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [tts_pkg::CFG_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_ISSUE,
        S_RD_DATA,
        S_WALK,
        S_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [tts_pkg::ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [tts_pkg::CFG_W-1:0]    siu_reg, siu_next;
    logic [tts_pkg::ACT_W-1:0]    act_reg, act_next;
    logic [tts_pkg::ST_W-1:0]     cur_reg, cur_next;
    logic [tts_pkg::ST_W-1:0]     tgt_reg, tgt_next;
    logic [tts_pkg::DRAW_W-1:0]   draw_reg, draw_next;
    logic [tts_pkg::ST_W-1:0]     fb_reg, fb_next;
    logic [tts_pkg::ST_W-1:0]     last_reg, last_next;
    logic [tts_pkg::ST_W-1:0]     idx_reg, idx_next;
    logic [tts_pkg::ST_W-1:0]     chk_reg, chk_next;
    logic                         pend_reg, pend_next;
    logic [tts_pkg::PROB_W-1:0]   res_val_reg, res_val_next;
    logic [tts_pkg::ST_W-1:0]     res_pick_reg, res_pick_next;
    logic                         res_fell_reg, res_fell_next;
    logic                         out_valid_reg, out_valid_next;
    logic [tts_pkg::PROB_W-1:0]   out_val_reg, out_val_next;
    logic [tts_pkg::ST_W-1:0]     out_pick_reg, out_pick_next;
    logic                         out_fell_reg, out_fell_next;

    logic                         in_fire;
    logic [tts_pkg::CFG_W-1:0]    row_len;
    logic                         wr_en;
    logic [tts_pkg::ADDR_W-1:0]   wr_addr;
    logic [tts_pkg::PROB_W-1:0]   wr_data;
    logic [tts_pkg::ADDR_W-1:0]   rd_addr;
    logic [tts_pkg::PROB_W-1:0]   rd_data;
    tts_pkg::acc_ctrl_t           acc_ctrl;
    logic                         acc_hit;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign read_value   = out_val_reg;
    assign picked_state = out_pick_reg;
    assign fell_through = out_fell_reg;

    assign row_len = (siu_reg > tts_pkg::ROW_MAX) ? tts_pkg::ROW_MAX : siu_reg;

    // clearing pass owns the write port until it is done
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {act, cur_state, target_state};
        wr_data = (prob_value > tts_pkg::ONE_Q16) ? tts_pkg::ONE_Q16 : prob_value;
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else if (in_fire && (tts_pkg::op_t'(op) == tts_pkg::OP_WRITE))
        begin
            wr_en = 1'b1;
        end
    end

    assign rd_addr = (state_reg == S_WALK) ? {act_reg, cur_reg, idx_reg}
                                           : {act_reg, cur_reg, tgt_reg};

    tts_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tts_accum u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (acc_ctrl),
        .addend (rd_data),
        .draw   (draw_reg),
        .hit    (acc_hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        siu_next       = siu_reg;
        act_next       = act_reg;
        cur_next       = cur_reg;
        tgt_next       = tgt_reg;
        draw_next      = draw_reg;
        fb_next        = fb_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        chk_next       = chk_reg;
        pend_next      = pend_reg;
        res_val_next   = res_val_reg;
        res_pick_next  = res_pick_reg;
        res_fell_next  = res_fell_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_pick_next  = out_pick_reg;
        out_fell_next  = out_fell_reg;
        acc_ctrl       = '0;

        if (cfg_valid && cfg_ready)
        begin
            siu_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == tts_pkg::LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    act_next  = act;
                    cur_next  = cur_state;
                    tgt_next  = target_state;
                    draw_next = uniform_draw;
                    fb_next   = fallback_pick;
                    last_next = tts_pkg::ST_W'(row_len - 1'b1);
                    idx_next  = '0;
                    pend_next = 1'b0;
                    unique case (tts_pkg::op_t'(op))
                        tts_pkg::OP_WRITE:
                        begin
                            state_next = S_IDLE;
                        end
                        tts_pkg::OP_READ:
                        begin
                            state_next = S_RD_ISSUE;
                        end
                        tts_pkg::OP_SAMPLE:
                        begin
                            acc_ctrl.clear = 1'b1;
                            if (row_len == '0)
                            begin
                                // empty row: always falls through
                                res_val_next  = '0;
                                res_pick_next = fallback_pick;
                                res_fell_next = 1'b1;
                                state_next    = S_DONE;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_ISSUE:
            begin
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                res_val_next  = rd_data;
                res_pick_next = '0;
                res_fell_next = 1'b0;
                state_next    = S_DONE;
            end
            S_WALK:
            begin
                // addresses run ahead: each entry's data returns in the cycle after its address
                idx_next  = idx_reg + 1'b1;
                chk_next  = idx_reg;
                pend_next = 1'b1;
                if (pend_reg)
                begin
                    acc_ctrl.add = 1'b1;
                    if (acc_hit)
                    begin
                        res_val_next  = '0;
                        res_pick_next = chk_reg;
                        res_fell_next = 1'b0;
                        pend_next     = 1'b0;
                        state_next    = S_DONE;
                    end
                    else if (chk_reg == last_reg)
                    begin
                        res_val_next  = '0;
                        res_pick_next = fb_reg;
                        res_fell_next = 1'b1;
                        pend_next     = 1'b0;
                        state_next    = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = res_val_reg;
                    out_pick_next  = res_pick_reg;
                    out_fell_next  = res_fell_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            siu_reg       <= tts_pkg::ROW_MAX;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            siu_reg       <= siu_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        cur_reg      <= cur_next;
        tgt_reg      <= tgt_next;
        draw_reg     <= draw_next;
        fb_reg       <= fb_next;
        last_reg     <= last_next;
        idx_reg      <= idx_next;
        chk_reg      <= chk_next;
        res_val_reg  <= res_val_next;
        res_pick_reg <= res_pick_next;
        res_fell_reg <= res_fell_next;
        out_val_reg  <= out_val_next;
        out_pick_reg <= out_pick_next;
        out_fell_reg <= out_fell_next;
    end

    // a new result enters the output register only from the done state
    a_out_from_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> $past(state_reg == S_DONE)
    ) else $error("result appeared outside done state");

    // one item at a time: a read or sample blocks the input
    a_single_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_fire && ((tts_pkg::op_t'(op) == tts_pkg::OP_READ)
                     || (tts_pkg::op_t'(op) == tts_pkg::OP_SAMPLE)))
            |=> !in_ready
    ) else $error("item accepted while previous item in progress");

    // a fall-through sample result never carries a read value
    a_fell_no_value: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && fell_through) |-> (read_value == '0)
    ) else $error("fall-through result carries a read value");

    // the walk adds only data whose read was issued the cycle before
    a_add_after_issue: assert property (
        @(posedge clk) disable iff (!rst_n)
        acc_ctrl.add |-> $past(state_reg == S_WALK)
    ) else $error("accumulate without a preceding read");

endmodule

`default_nettype wire
